// ===== rtl/itad_pkg.sv =====
// Shared types, constants and character lookup for the integer-to-ASCII converter.
`default_nettype none

package itad_pkg;

  // ASCII codes used by the emitter
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // Digit-to-character lookup, lowercase hex
  localparam logic [7:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Controls from the sequencer to the digit shift register
  typedef struct packed {
    logic load;         // capture magnitude, clear digits
    logic convert;      // one shift-and-adjust step
    logic hex;          // skip decimal adjust
    logic shift_digit;  // drop the top digit
  } ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] digit);
    digit_char = DIGIT_CHARS[digit];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_digits.sv =====
// Top level: sequencer and character output for the integer-to-ASCII converter.
// Sequence: conversion one bit per cycle through the digit shift register, then
//   leading zero digits are skipped, then a decision step that also carries '-'
//   when negative, then the printed digits go out one per cycle.
// A new number is taken only once busy is low again after the final character;
//   the receiver cannot stall.
// Reset: rst (synchronous) returns to idle and clears the strobe; digit data is not reset.
`default_nettype none

module integer_to_ascii_digits #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  mode,
  output logic                       strobe,
  output logic      [7:0]            char_code,
  output logic                       last
);

  // Decimal digits of 2^VALUE_BITS; also covers the hex nibbles
  localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCW   = $clog2(VALUE_BITS + 1);
  localparam int DCW   = $clog2(NDIG + 1);

  typedef enum logic [1:0] {IDLE, CONV, SKIP, EMIT} state_t;

  state_t                state;
  logic [BCW-1:0]        bit_cnt;
  logic [DCW-1:0]        dig_cnt;
  logic                  hex;
  logic                  neg;
  itad_pkg::ctrl_t       ctrl;
  logic [3:0]            top_digit;
  logic                  accept;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] magnitude;

  assign accept    = start && (state == IDLE);
  assign busy      = (state != IDLE);
  assign in_neg    = !mode && value[VALUE_BITS-1];
  assign magnitude = in_neg ? VALUE_BITS'(~value + VALUE_BITS'(1)) : value;

  // Drive the digit shift register
  always_comb begin
    ctrl.load        = accept;
    ctrl.convert     = (state == CONV);
    ctrl.hex         = hex;
    ctrl.shift_digit = ((state == SKIP) && (top_digit == 4'h0) && (dig_cnt > DCW'(1)))
                       || (state == EMIT);
  end

  itad_dabble #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_value(magnitude),
    .top_digit (top_digit)
  );

  // Sequence conversion, zero skipping and character transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            hex     <= mode;
            neg     <= in_neg;
            bit_cnt <= BCW'(VALUE_BITS);
            state   <= CONV;
          end
        end
        CONV: begin
          bit_cnt <= bit_cnt - BCW'(1);
          if (bit_cnt == BCW'(1)) begin
            dig_cnt <= DCW'(NDIG);
            state   <= SKIP;
          end
        end
        SKIP: begin
          if ((top_digit == 4'h0) && (dig_cnt > DCW'(1))) begin
            dig_cnt <= dig_cnt - DCW'(1);
          end else begin
            if (neg) begin
              strobe    <= 1'b1;
              char_code <= itad_pkg::CHAR_MINUS;
              last      <= 1'b0;
            end
            state <= EMIT;
          end
        end
        EMIT: begin
          strobe    <= 1'b1;
          char_code <= itad_pkg::digit_char(top_digit);
          last      <= (dig_cnt == DCW'(1));
          dig_cnt   <= dig_cnt - DCW'(1);
          if (dig_cnt == DCW'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Characters of one number go out back to back
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap between characters of one number");

  // The final character ends the run
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("still busy after final character");

  // No character in the cycle after a number is taken
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("character transfer right after start");

  // Digit count never runs out while printing
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (dig_cnt != '0))
    else $error("digit count empty during emit");

endmodule

`default_nettype wire

// ===== rtl/itad_dabble.sv =====
// Bit-serial binary to BCD/hex digit shift register (shift-and-add-3).
`default_nettype none

module itad_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  wire logic                  clk,
  input  wire itad_pkg::ctrl_t       ctrl,
  input  wire logic [VALUE_BITS-1:0] load_value,
  output logic      [3:0]            top_digit
);

  localparam int DW = NDIG * 4;

  logic [VALUE_BITS-1:0] bin;
  logic [DW-1:0]         bcd;
  logic [DW-1:0]         adjusted;

  // In decimal mode, add 3 to each decimal digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (!ctrl.hex && (bcd[i*4 +: 4] >= 4'd5)) begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  // Load, convert one bit per cycle, or advance one digit
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= load_value;
      bcd <= '0;
    end else if (ctrl.convert) begin
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
      bcd <= {adjusted[DW-2:0], bin[VALUE_BITS-1]};
    end else if (ctrl.shift_digit) begin
      bcd <= {bcd[DW-5:0], 4'h0};
    end
  end

  assign top_digit = bcd[DW-1 -: 4];

endmodule

`default_nettype wire
